@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL; plist_seq.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define PL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define PL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/plist_pkg.sv @@
`default_nettype none

package plist_pkg;

	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_BACK  = 3'd1;
	localparam logic [2:0] ACT_INS_POS   = 3'd2;
	localparam logic [2:0] ACT_DELETE    = 3'd3;
	localparam logic [2:0] ACT_SEARCH    = 3'd4;

	typedef enum logic [2:0] {
		STAT_DONE   = 3'd0,
		STAT_POS_NF = 3'd1,
		STAT_EMPTY  = 3'd2,
		STAT_FULL   = 3'd3,
		STAT_VAL_NF = 3'd4,
		STAT_FOUND  = 3'd5
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] match_position;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/positional_list_engine_unit.sv @@
// Insert and delete: one memory read and one write per cycle while entries are moved.
// Search: one entry compared per cycle, except while an earlier match waits for the
// result side to take it. One request is in work at a time; two finished results are
// buffered. Reset clears the element count, the state and the pipeline flags at once;
// the element memory is not cleared and needs no clearing pass.
`default_nettype none

module positional_list_engine_unit #(
	parameter int DEPTH = 32,
	parameter int ELEMENT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // value [31:0], position [37:32], zero [39:38]
	input  wire logic [2:0]  s_axis_tuser,  // action [2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // match_position [5:0], zero [7:6]
	output logic [2:0]       m_axis_tuser,  // status [2:0]
	output logic             m_axis_tlast
);

	import plist_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic                     mem_rd_en;
	logic [IW-1:0]            mem_rd_addr;
	logic [ELEMENT_WIDTH-1:0] mem_rd_data;
	logic                     mem_we;
	logic [IW-1:0]            mem_wr_addr;
	logic [ELEMENT_WIDTH-1:0] mem_wr_data;
	logic                     res_valid;
	logic                     res_ready;
	res_t                     res;
	res_t                     out_res;

	plist_mem #(
		.DEPTH(DEPTH),
		.WIDTH(ELEMENT_WIDTH)
	) u_mem (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_we),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	plist_seq #(
		.DEPTH(DEPTH),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_action  (s_axis_tuser),
		.req_value   (s_axis_tdata[31:0]),
		.req_position(s_axis_tdata[37:32]),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_we      (mem_we),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	plist_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.match_position};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

@@ rtl/plist_mem.sv @@
`default_nettype none

module plist_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/plist_obuf.sv @@
`default_nettype none

module plist_obuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire plist_pkg::res_t in_res,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output plist_pkg::res_t      out_res
);

	import plist_pkg::*;

	res_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = ent_q[0];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				ent_q[cnt_q[0]] <= in_res;
			end
			2'b01: begin
				ent_q[0] <= ent_q[1];
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent_q[0] <= in_res;
				end else begin
					ent_q[0] <= ent_q[1];
					ent_q[1] <= in_res;
				end
			end
			2'b00: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/plist_seq.sv @@
`default_nettype none
`include "assert_macros.svh"

module plist_seq #(
	parameter int DEPTH = 32,
	parameter int ELEMENT_WIDTH = 32,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_ready,
	input  wire logic [2:0]               req_action,
	input  wire logic signed [31:0]       req_value,
	input  wire logic [5:0]               req_position,
	output logic                          mem_rd_en,
	output logic [IW-1:0]                 mem_rd_addr,
	input  wire logic [ELEMENT_WIDTH-1:0] mem_rd_data,
	output logic                          mem_we,
	output logic [IW-1:0]                 mem_wr_addr,
	output logic [ELEMENT_WIDTH-1:0]      mem_wr_data,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output plist_pkg::res_t               res
);

	import plist_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            rem_q;
	logic                     vld_s1;
	logic                     pend_q;
	logic                     ins_q;
	logic [IW-1:0]            idx_q;
	logic [ELEMENT_WIDTH-1:0] word_q;
	logic [IW-1:0]            rd_idx_q;
	logic [IW-1:0]            idx_s1;
	logic [5:0]               pend_pos_q;
	status_t                  rstat_q;
	logic [5:0]               rpos_q;

	logic signed [63:0]       val_ext;
	logic [ELEMENT_WIDTH-1:0] word_in;
	int                       pos_i;
	int                       cnt_i;
	logic                     accept;
	logic                     d_shift;
	logic                     d_scan;
	logic                     d_resp;
	logic                     d_ins;
	logic [IW-1:0]            d_idx;
	status_t                  d_stat;
	logic                     busy;
	logic                     match;
	logic                     stall;
	logic                     issue;
	logic                     drained;

	assign val_ext   = 64'(req_value);
	assign word_in   = val_ext[ELEMENT_WIDTH-1:0];
	assign pos_i     = int'(req_position);
	assign cnt_i     = int'(count_q);
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		d_shift = 1'b0;
		d_scan  = 1'b0;
		d_resp  = 1'b0;
		d_ins   = 1'b1;
		d_idx   = '0;
		d_stat  = STAT_DONE;
		case (req_action)
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
				if (cnt_i == DEPTH) begin
					d_resp = 1'b1;
					d_stat = STAT_FULL;
				end else if (req_action == ACT_INS_FRONT) begin
					d_shift = 1'b1;
				end else if (req_action == ACT_INS_BACK) begin
					d_shift = 1'b1;
					d_idx   = IW'(count_q);
				end else if (pos_i == 1) begin
					d_shift = 1'b1;
				end else if (pos_i > 1 && pos_i <= cnt_i) begin
					d_shift = 1'b1;
					d_idx   = IW'(pos_i - 1);
				end else begin
					d_resp = 1'b1;
					d_stat = STAT_POS_NF;
				end
			end
			ACT_DELETE: begin
				d_ins = 1'b0;
				if (cnt_i == 0) begin
					d_resp = 1'b1;
					d_stat = STAT_EMPTY;
				end else if (pos_i >= 1 && pos_i <= cnt_i) begin
					d_shift = 1'b1;
					d_idx   = IW'(pos_i - 1);
				end else begin
					d_resp = 1'b1;
					d_stat = STAT_POS_NF;
				end
			end
			ACT_SEARCH: begin
				d_ins = 1'b0;
				if (cnt_i == 0) begin
					d_resp = 1'b1;
					d_stat = STAT_EMPTY;
				end else begin
					d_scan = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Inserts walk downwards and deletes upwards, so a write never lands on an entry
	// that is still to be read and no forwarding is needed.
	assign busy    = (state_q == ST_SHIFT) || (state_q == ST_SCAN);
	assign match   = vld_s1 && (mem_rd_data == word_q);
	assign stall   = (state_q == ST_SCAN) && match && pend_q && !res_ready;
	assign issue   = busy && (rem_q != '0) && !stall;
	assign drained = (rem_q == '0) && !vld_s1;

	assign mem_rd_en   = issue;
	assign mem_rd_addr = rd_idx_q;
	assign mem_we      = (state_q == ST_SHIFT) && (vld_s1 || (drained && ins_q));
	assign mem_wr_addr = vld_s1 ? (ins_q ? idx_s1 + IW'(1) : idx_s1 - IW'(1)) : idx_q;
	assign mem_wr_data = vld_s1 ? mem_rd_data : word_q;

	assign res_valid = (state_q == ST_RESP) || ((state_q == ST_SCAN) && match && pend_q);
	assign res.status         = (state_q == ST_RESP) ? rstat_q : STAT_FOUND;
	assign res.match_position = (state_q == ST_RESP) ? rpos_q : pend_pos_q;
	assign res.last           = (state_q == ST_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					pend_q <= 1'b0;
					if (accept && d_shift) begin
						state_q <= ST_SHIFT;
						if (d_ins) begin
							rem_q <= count_q - CW'(d_idx);
						end else begin
							rem_q <= count_q - CW'(d_idx) - CW'(1);
						end
					end else if (accept && d_scan) begin
						state_q <= ST_SCAN;
						rem_q   <= count_q;
					end else if (accept && d_resp) begin
						state_q <= ST_RESP;
					end
				end
				ST_SHIFT, ST_SCAN: begin
					if (!stall) begin
						vld_s1 <= issue;
						if (issue) begin
							rem_q <= rem_q - CW'(1);
						end
						if (state_q == ST_SCAN && match) begin
							pend_q <= 1'b1;
						end
					end
					if (drained) begin
						state_q <= ST_RESP;
						if (state_q == ST_SHIFT) begin
							count_q <= ins_q ? count_q + CW'(1) : count_q - CW'(1);
						end
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ins_q   <= d_ins;
				idx_q   <= d_idx;
				word_q  <= word_in;
				rstat_q <= d_stat;
				rpos_q  <= '0;
				if (d_ins) begin
					rd_idx_q <= IW'(count_q - CW'(1));
				end else if (d_scan) begin
					rd_idx_q <= '0;
				end else begin
					rd_idx_q <= d_idx + IW'(1);
				end
			end
			ST_SHIFT, ST_SCAN: begin
				if (!stall) begin
					idx_s1 <= rd_idx_q;
					if (issue) begin
						rd_idx_q <= ins_q ? rd_idx_q - IW'(1) : rd_idx_q + IW'(1);
					end
					if (state_q == ST_SCAN && match) begin
						pend_pos_q <= 6'(32'(idx_s1) + 1);
					end
				end
				if (drained) begin
					if (state_q == ST_SHIFT) begin
						rstat_q <= STAT_DONE;
						rpos_q  <= '0;
					end else begin
						rstat_q <= pend_q ? STAT_FOUND : STAT_VAL_NF;
						rpos_q  <= pend_q ? pend_pos_q : 6'd0;
					end
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	`PL_ASSERT(a_count_range, clk, arst_n, 32'(count_q) <= DEPTH, "Element count exceeds depth.")
	`PL_ASSERT_IMPL(a_write_in_shift, clk, arst_n, mem_we, state_q == ST_SHIFT, "Memory written outside a shift.")
	`PL_ASSERT_IMPL(a_pipe_busy, clk, arst_n, vld_s1, state_q == ST_SHIFT || state_q == ST_SCAN, "Read data pending while idle.")
	`PL_ASSERT_NEXT(a_count_hold, clk, arst_n, state_q != ST_SHIFT, count_q == $past(count_q), "Element count changed outside a shift.")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import plist_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [2:0] ACT_FIRST_UNDEF = 3'd5;
	localparam logic [2:0] ACT_LAST_UNDEF  = 3'd7;

	typedef enum logic [1:0] {
		PH_GROW,
		PH_CHURN,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] val;
		logic [5:0]  pos;
		logic        typed;
		status_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // value [31:0], position [37:32], zero [39:38]
	logic [2:0]  s_axis_tuser = '0;  // action [2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;      // match_position [5:0], zero [7:6]
	logic [2:0]  m_axis_tuser;      // status [2:0]
	logic        m_axis_tlast;

	logic [31:0] list_words [DEPTH];
	int          list_len = 0;
	res_t        step_results [$];
	res_t        awaited [$];
	res_t        oldest;
	int          faults = 0;
	int          stall_left = 0;
	bit          steady = 1'b0;

	logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h0000_0001, 32'h0000_002A, 32'hDEAD_BEEF, 32'h1234_5678};

	plan_row_t plan [25] = '{
		'{ACT_DELETE,    32'h0000_0000, 6'd1,  1'b1, STAT_EMPTY},
		'{ACT_SEARCH,    32'h0000_0000, 6'd0,  1'b1, STAT_EMPTY},
		'{ACT_INS_BACK,  32'h7FFF_FFFF, 6'd0,  1'b1, STAT_DONE},
		'{ACT_INS_FRONT, 32'h8000_0000, 6'd0,  1'b1, STAT_DONE},
		'{ACT_INS_POS,   32'h0000_0001, 6'd0,  1'b1, STAT_POS_NF},
		'{ACT_INS_POS,   32'h0000_0001, 6'd63, 1'b1, STAT_POS_NF},
		'{ACT_INS_POS,   32'hFFFF_FFFF, 6'd1,  1'b1, STAT_DONE},
		'{ACT_INS_POS,   32'h0000_0000, 6'd3,  1'b0, STAT_DONE},
		'{ACT_INS_POS,   32'h0000_0005, 6'd5,  1'b1, STAT_POS_NF},
		'{ACT_INS_BACK,  32'h7FFF_FFFF, 6'd0,  1'b0, STAT_DONE},
		'{ACT_SEARCH,    32'h7FFF_FFFF, 6'd0,  1'b0, STAT_DONE},
		'{ACT_SEARCH,    32'h0000_0005, 6'd0,  1'b0, STAT_DONE},
		'{ACT_FIRST_UNDEF, 32'hFFFF_FFFF, 6'd63, 1'b0, STAT_DONE},
		'{ACT_LAST_UNDEF,  32'h0000_0000, 6'd1,  1'b0, STAT_DONE},
		'{ACT_DELETE,    32'h0000_0000, 6'd0,  1'b1, STAT_POS_NF},
		'{ACT_DELETE,    32'h0000_0000, 6'd63, 1'b1, STAT_POS_NF},
		'{ACT_DELETE,    32'h0000_0000, 6'd5,  1'b1, STAT_DONE},
		'{ACT_DELETE,    32'h0000_0000, 6'd1,  1'b1, STAT_DONE},
		'{ACT_SEARCH,    32'h8000_0000, 6'd0,  1'b0, STAT_DONE},
		'{ACT_DELETE,    32'h0000_0000, 6'd1,  1'b1, STAT_DONE},
		'{ACT_DELETE,    32'h0000_0000, 6'd1,  1'b1, STAT_DONE},
		'{ACT_DELETE,    32'h0000_0000, 6'd1,  1'b1, STAT_DONE},
		'{ACT_INS_POS,   32'h0000_002A, 6'd1,  1'b1, STAT_DONE},
		'{ACT_SEARCH,    32'h0000_002A, 6'd0,  1'b0, STAT_DONE},
		'{ACT_INS_FRONT, 32'h0000_002A, 6'd0,  1'b0, STAT_DONE}
	};

	positional_list_engine_unit #(
		.DEPTH(DEPTH),
		.ELEMENT_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 70) begin
			return 0;
		end
		if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic place_word(input int idx, input logic [31:0] word);
		for (int i = list_len; i > idx; i--) begin
			list_words[i] = list_words[i - 1];
		end
		list_words[idx] = word;
		list_len++;
	endtask

	// Applies one accepted request to the shadow list and leaves its results in step_results.
	task automatic model_request(input logic [2:0] act, input logic [31:0] val,
			input logic [5:0] pos);
		res_t r;
		step_results.delete();
		r = '{STAT_DONE, 6'd0, 1'b1};
		case (act)
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
				if (list_len == DEPTH) begin
					r.status = STAT_FULL;
				end else if (act == ACT_INS_FRONT || (act == ACT_INS_POS && pos == 6'd1)) begin
					place_word(0, val);
				end else if (act == ACT_INS_BACK) begin
					place_word(list_len, val);
				end else if (pos > 6'd1 && pos <= list_len) begin
					place_word(int'(pos) - 1, val);
				end else begin
					r.status = STAT_POS_NF;
				end
				step_results.push_back(r);
			end
			ACT_DELETE: begin
				if (list_len == 0) begin
					r.status = STAT_EMPTY;
				end else if (pos >= 6'd1 && pos <= list_len) begin
					for (int i = int'(pos) - 1; i + 1 < list_len; i++) begin
						list_words[i] = list_words[i + 1];
					end
					list_len--;
				end else begin
					r.status = STAT_POS_NF;
				end
				step_results.push_back(r);
			end
			ACT_SEARCH: begin
				if (list_len == 0) begin
					r.status = STAT_EMPTY;
					step_results.push_back(r);
				end else begin
					for (int i = 0; i < list_len; i++) begin
						if (list_words[i] == val) begin
							step_results.push_back('{STAT_FOUND, 6'(i + 1), 1'b0});
						end
					end
					if (step_results.size() == 0) begin
						r.status = STAT_VAL_NF;
					end else begin
						r = step_results.pop_back();
						r.last = 1'b1;
					end
					step_results.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_request(input logic [2:0] act, input logic [31:0] val,
			input logic [5:0] pos, input logic typed, input status_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, pos, val};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		model_request(act, val, pos);
		if (typed) begin
			awaited.push_back('{want, 6'd0, 1'b1});
		end else begin
			foreach (step_results[i]) begin
				awaited.push_back(step_results[i]);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited.size() == 0) begin
				if (faults < 10) begin
					$display("unexpected result: status %0d position %0d last %0d",
						m_axis_tuser, m_axis_tdata[5:0], m_axis_tlast);
				end
				faults++;
			end else begin
				oldest = awaited.pop_front();
				if (m_axis_tuser !== oldest.status || m_axis_tdata[5:0] !== oldest.match_position
						|| m_axis_tlast !== oldest.last) begin
					if (faults < 10) begin
						$display("mismatch: status %0d/%0d position %0d/%0d last %0d/%0d",
							oldest.status, m_axis_tuser, oldest.match_position,
							m_axis_tdata[5:0], oldest.last, m_axis_tlast);
					end
					faults++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	initial begin
		phase_t      phase;
		int          counted;
		int          phase_items;
		int          edge_hits;
		int          roll;
		logic [2:0]  act;
		logic [31:0] val;
		logic [5:0]  pos;

		phase = PH_GROW;
		counted = 0;
		phase_items = 0;
		edge_hits = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_request(plan[i].act, plan[i].val, plan[i].pos, plan[i].typed, plan[i].want);
		end

		// Fill to the brim, churn, then drain past empty, round after round.
		while (counted < 445) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				act = 3'($urandom_range(ACT_FIRST_UNDEF, ACT_LAST_UNDEF));
			end else begin
				case (phase)
					PH_GROW: begin
						if (roll < 80) begin
							act = ACT_INS_FRONT + 3'($urandom_range(0, 2));
						end else if (roll < 92) begin
							act = ACT_SEARCH;
						end else begin
							act = ACT_DELETE;
						end
					end
					PH_DRAIN: begin
						if (roll < 72) begin
							act = ACT_DELETE;
						end else if (roll < 92) begin
							act = ACT_SEARCH;
						end else begin
							act = ACT_INS_FRONT + 3'($urandom_range(0, 2));
						end
					end
					default: begin
						act = 3'($urandom_range(ACT_INS_FRONT, ACT_SEARCH));
					end
				endcase
			end
			if ($urandom_range(0, 9) < 6) begin
				val = value_pool[3'($urandom_range(0, 7))];
			end else begin
				val = $urandom();
			end
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				pos = 6'($urandom_range(1, (list_len > 1) ? list_len : 1));
			end else if (roll < 8) begin
				pos = 6'(list_len + 1);
			end else begin
				pos = 6'($urandom_range(0, 63));
			end

			send_request(act, val, pos, 1'b0, STAT_DONE);
			if (act <= ACT_SEARCH) begin
				counted++;
			end
			phase_items++;

			case (phase)
				PH_GROW: begin
					if (list_len == DEPTH) begin
						edge_hits++;
					end
					if (edge_hits >= 4) begin
						phase = PH_CHURN;
						phase_items = 0;
						edge_hits = 0;
						steady = ($urandom_range(0, 3) == 0);
					end
				end
				PH_CHURN: begin
					if (phase_items >= 60) begin
						phase = PH_DRAIN;
						steady = ($urandom_range(0, 3) == 0);
					end
				end
				default: begin
					if (list_len == 0) begin
						edge_hits++;
					end
					if (edge_hits >= 3) begin
						phase = PH_GROW;
						edge_hits = 0;
						steady = ($urandom_range(0, 3) == 0);
					end
				end
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
		if (faults == 0 && awaited.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
